### rtl/ohm_pkg.sv
// shared types and constants for the open addressing hash map
`default_nettype none
package ohm_pkg;

  // command codes
  localparam logic [2:0] CMD_SET    = 3'd0;
  localparam logic [2:0] CMD_ADD    = 3'd1;
  localparam logic [2:0] CMD_GET    = 3'd2;
  localparam logic [2:0] CMD_REMOVE = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;

  // status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_ABSENT  = 2'd1;
  localparam logic [1:0] ST_PRESENT = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // configuration register indexes
  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_KEY_MODE = 1'b1;

  // slot tag codes
  localparam logic [31:0] TAG_EMPTY = 32'd0;
  localparam logic [31:0] TAG_TOMB  = 32'd1;

  localparam int CNT_OUT_W = 11;
  localparam logic [3:0] CAP_RESET = 4'd6;

  // folded key and its slot tag
  typedef struct packed {
    logic [31:0] tag;
    logic [63:0] key;
  } hash_t;

endpackage
`default_nettype wire

### rtl/ohm_if.sv
// command and response channel interfaces
`default_nettype none
interface ohm_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [63:0] key;
  logic [63:0] value;
  modport source (output valid, command, key, value, input ready);
  modport sink (input valid, command, key, value, output ready);
endinterface

interface ohm_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        found;
  logic [63:0] read_value;
  logic [10:0] live_count;
  logic [10:0] tombstone_count;
  modport source (output valid, status, found, read_value, live_count, tombstone_count,
                  input ready);
  modport sink (input valid, status, found, read_value, live_count, tombstone_count,
                output ready);
endinterface
`default_nettype wire

### rtl/open_addressing_hash_map_unit.sv
// top level: linear probing hash map over one slot memory
//
//  channel  dir  signals                                   handshake
//  cmd_i    in   command, key, value                       valid/ready
//  rsp_o    out  status, found, read_value, live/tomb cnt  valid/ready
//  cfg      in   cfg_we_i, cfg_index_i, cfg_data_i         write on enable
//
// a probe issues its first read from idle, visits the chain one slot at a time
// and posts the result from the final state, a pace set by the single read port
// of the slot memory.
// clear, and reset, sweep all SLOT_COUNT slots, one per cycle, with cmd ready low.
// rsp_o is a register: a stalled result holds the block in its final state.
`default_nettype none
module open_addressing_hash_map_unit #(
  parameter int SLOT_COUNT  = 1024,
  parameter int KEY_WIDTH   = 64,
  parameter int VALUE_WIDTH = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  ohm_cmd_if.sink         cmd_i,
  ohm_rsp_if.source       rsp_o,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_index_i,
  input  wire logic [3:0] cfg_data_i
);
  localparam int IDX_W  = $clog2(SLOT_COUNT);
  localparam int SLOT_W = IDX_W + 1;
  localparam int LG_W   = $clog2(IDX_W + 1);
  localparam int FW     = SLOT_W + 3;
  localparam int MEM_W  = 32 + KEY_WIDTH + VALUE_WIDTH;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CLR   = 2'd1;
  localparam logic [1:0] S_PROBE = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  function automatic logic [LG_W-1:0] clamp_lg(input logic [3:0] lg);
    logic [LG_W-1:0] r;
    if (lg < 4'd2) begin
      r = LG_W'(2);
    end else if (int'(lg) > IDX_W) begin
      r = LG_W'(IDX_W);
    end else begin
      r = LG_W'(lg);
    end
    return r;
  endfunction

  logic [1:0]             state_q, state_d;
  logic [3:0]             cap_reg_q;
  logic                   mode_q;
  logic [LG_W-1:0]        cap_lg_q, cap_lg_d;
  logic [SLOT_W-1:0]      live_q, live_d, tomb_q, tomb_d;
  logic [IDX_W-1:0]       idx_q, idx_d, tidx_q, tidx_d, clr_q, clr_d;
  logic [SLOT_W-1:0]      n_q, n_d;
  logic                   tvld_q, tvld_d, clr_res_q, clr_res_d;
  logic [2:0]             cmd_q, cmd_d;
  ohm_pkg::hash_t         hk_q, hk_d, hk_in;
  logic [VALUE_WIDTH-1:0] val_q, val_d;
  logic [1:0]             st_q, st_d;
  logic                   fnd_q, fnd_d;
  logic [VALUE_WIDTH-1:0] rv_q, rv_d;
  logic                   rv_valid_q, rv_valid_d;
  logic [1:0]             ost_q, ost_d;
  logic                   ofnd_q, ofnd_d;
  logic [VALUE_WIDTH-1:0] orv_q, orv_d;
  logic [SLOT_W-1:0]      olive_q, olive_d, otomb_q, otomb_d;

  logic [SLOT_W-1:0]      slots;
  logic [IDX_W-1:0]       mask, start_idx, next_idx, ins_at;
  logic                   we;
  logic [IDX_W-1:0]       waddr, raddr;
  logic [MEM_W-1:0]       wdata, rdata;
  logic [31:0]            rd_tag;
  logic [KEY_WIDTH-1:0]   rd_key;
  logic [VALUE_WIDTH-1:0] rd_val;
  logic                   is_empty, is_tomb, is_hit, last, tnow_vld, ins_ok, full;
  logic [FW-1:0]          used4, cap3;

  // hash of the incoming key
  ohm_keyfold #(.KEY_WIDTH(KEY_WIDTH)) u_fold (
    .key_i  (cmd_i.key),
    .mode_i (mode_q),
    .hk_o   (hk_in)
  );

  // slot memory: tag, key, value
  ohm_ram #(.WIDTH(MEM_W), .DEPTH(SLOT_COUNT)) u_slots (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // geometry and slot decode
  always_comb begin
    slots     = SLOT_W'(1) << cap_lg_q;
    mask      = slots[IDX_W-1:0] - 1'b1;
    start_idx = hk_in.tag[IDX_W-1:0] & mask;
    next_idx  = (idx_q + 1'b1) & mask;
    rd_tag    = rdata[MEM_W-1 -: 32];
    rd_key    = rdata[VALUE_WIDTH +: KEY_WIDTH];
    rd_val    = rdata[VALUE_WIDTH-1:0];
    is_empty  = rd_tag == ohm_pkg::TAG_EMPTY;
    is_tomb   = rd_tag == ohm_pkg::TAG_TOMB;
    is_hit    = !is_empty && !is_tomb && rd_tag == hk_q.tag
                && rd_key == hk_q.key[KEY_WIDTH-1:0];
    last      = n_q == (slots - 1'b1);
    tnow_vld  = tvld_q || is_tomb;
    ins_at    = tvld_q ? tidx_q : idx_q;
    ins_ok    = tnow_vld || is_empty;
    used4     = (FW'(live_q) + FW'(tomb_q) + FW'(1)) << 2;
    cap3      = FW'(slots) * FW'(3);
    full      = (used4 > cap3) || !ins_ok;
    raddr     = (state_q == S_IDLE) ? start_idx : next_idx;
  end

  assign cmd_i.ready = state_q == S_IDLE;

  // command sequencer
  always_comb begin
    state_d    = state_q;
    cap_lg_d   = cap_lg_q;
    live_d     = live_q;
    tomb_d     = tomb_q;
    idx_d      = idx_q;
    tidx_d     = tidx_q;
    clr_d      = clr_q;
    n_d        = n_q;
    tvld_d     = tvld_q;
    clr_res_d  = clr_res_q;
    cmd_d      = cmd_q;
    hk_d       = hk_q;
    val_d      = val_q;
    st_d       = st_q;
    fnd_d      = fnd_q;
    rv_d       = rv_q;
    rv_valid_d = rv_valid_q;
    ost_d      = ost_q;
    ofnd_d     = ofnd_q;
    orv_d      = orv_q;
    olive_d    = olive_q;
    otomb_d    = otomb_q;
    we         = 1'b0;
    waddr      = idx_q;
    wdata      = {rd_tag, rd_key, val_q};
    unique case (state_q)
      S_IDLE: begin
        if (cmd_i.valid) begin
          cmd_d  = cmd_i.command;
          hk_d   = hk_in;
          val_d  = cmd_i.value[VALUE_WIDTH-1:0];
          st_d   = ohm_pkg::ST_DONE;
          fnd_d  = 1'b0;
          rv_d   = '0;
          idx_d  = start_idx;
          n_d    = '0;
          tvld_d = 1'b0;
          if (cmd_i.command <= ohm_pkg::CMD_REMOVE) begin
            state_d = S_PROBE;
          end else if (cmd_i.command == ohm_pkg::CMD_CLEAR) begin
            state_d   = S_CLR;
            clr_d     = '0;
            clr_res_d = 1'b1;
            cap_lg_d  = clamp_lg(cap_reg_q);
            live_d    = '0;
            tomb_d    = '0;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_CLR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == IDX_W'(SLOT_COUNT - 1)) begin
          state_d = clr_res_q ? S_FIN : S_IDLE;
        end
      end
      S_PROBE: begin
        if (is_empty || is_hit || last) begin
          state_d = S_FIN;
          fnd_d   = is_hit;
          case (cmd_q) inside
            ohm_pkg::CMD_SET, ohm_pkg::CMD_ADD: begin
              if (is_hit) begin
                if (cmd_q == ohm_pkg::CMD_SET) begin
                  we = 1'b1;
                end else begin
                  st_d = ohm_pkg::ST_PRESENT;
                end
              end else if (full) begin
                st_d = ohm_pkg::ST_FULL;
              end else begin
                we     = 1'b1;
                waddr  = tnow_vld ? (tvld_q ? tidx_q : idx_q) : ins_at;
                wdata  = {hk_q.tag, hk_q.key[KEY_WIDTH-1:0], val_q};
                live_d = live_q + 1'b1;
                if (tnow_vld) begin
                  tomb_d = tomb_q - 1'b1;
                end
              end
            end
            ohm_pkg::CMD_GET: begin
              if (is_hit) begin
                rv_d = rd_val;
              end else begin
                st_d = ohm_pkg::ST_ABSENT;
              end
            end
            default: begin
              if (is_hit) begin
                we     = 1'b1;
                wdata  = {ohm_pkg::TAG_TOMB, {(KEY_WIDTH + VALUE_WIDTH){1'b0}}};
                live_d = live_q - 1'b1;
                tomb_d = tomb_q + 1'b1;
              end else begin
                st_d = ohm_pkg::ST_ABSENT;
              end
            end
          endcase
        end else begin
          if (is_tomb && !tvld_q) begin
            tvld_d = 1'b1;
            tidx_d = idx_q;
          end
          idx_d = next_idx;
          n_d   = n_q + 1'b1;
        end
      end
      S_FIN: begin
        if (!rv_valid_q || rsp_o.ready) begin
          state_d    = S_IDLE;
          clr_res_d  = 1'b0;
          rv_valid_d = 1'b1;
          ost_d      = st_q;
          ofnd_d     = fnd_q;
          orv_d      = rv_q;
          olive_d    = live_q;
          otomb_d    = tomb_q;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (state_q != S_FIN && rsp_o.ready) begin
      rv_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLR;
      cap_reg_q  <= ohm_pkg::CAP_RESET;
      mode_q     <= 1'b0;
      cap_lg_q   <= clamp_lg(ohm_pkg::CAP_RESET);
      live_q     <= '0;
      tomb_q     <= '0;
      clr_q      <= '0;
      clr_res_q  <= 1'b0;
      rv_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cap_lg_q   <= cap_lg_d;
      live_q     <= live_d;
      tomb_q     <= tomb_d;
      clr_q      <= clr_d;
      clr_res_q  <= clr_res_d;
      rv_valid_q <= rv_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          ohm_pkg::REG_CAPACITY: cap_reg_q <= cfg_data_i;
          ohm_pkg::REG_KEY_MODE: mode_q    <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    tidx_q  <= tidx_d;
    n_q     <= n_d;
    tvld_q  <= tvld_d;
    cmd_q   <= cmd_d;
    hk_q    <= hk_d;
    val_q   <= val_d;
    st_q    <= st_d;
    fnd_q   <= fnd_d;
    rv_q    <= rv_d;
    ost_q   <= ost_d;
    ofnd_q  <= ofnd_d;
    orv_q   <= orv_d;
    olive_q <= olive_d;
    otomb_q <= otomb_d;
  end

  // response outputs
  assign rsp_o.valid           = rv_valid_q;
  assign rsp_o.status          = ost_q;
  assign rsp_o.found           = ofnd_q;
  assign rsp_o.read_value      = 64'(orv_q);
  assign rsp_o.live_count      = ohm_pkg::CNT_OUT_W'(olive_q);
  assign rsp_o.tombstone_count = ohm_pkg::CNT_OUT_W'(otomb_q);

  // occupancy never exceeds the slots in use
  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (FW'(live_q) + FW'(tomb_q)) <= FW'(slots))
    else $error("live plus tombstone count exceeds slots in use");

  // slot memory is written only by a sweep or a probe
  a_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q == S_CLR || state_q == S_PROBE))
    else $error("slot write while idle");

  // an accepted item leaves the idle state
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.valid && cmd_i.ready) |=> state_q != S_IDLE)
    else $error("accepted item did not start");

  // a probe never walks past the slots in use
  a_probe_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PROBE |-> n_q < slots)
    else $error("probe walked past every slot");
endmodule
`default_nettype wire

### rtl/ohm_ram.sv
// generic single-write, single-read ram with registered read
`default_nettype none
module ohm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

### rtl/ohm_keyfold.sv
// key masking, hash fold and tag forming
`default_nettype none
module ohm_keyfold #(
  parameter int KEY_WIDTH = 64
) (
  input  wire logic          [63:0] key_i,
  input  wire logic                 mode_i,
  output ohm_pkg::hash_t            hk_o
);
  localparam logic [63:0] KeyMask = {64{1'b1}} >> (64 - KEY_WIDTH);

  logic [63:0] k;
  logic [31:0] h;

  // 32-bit identity in mode 0, low xor high in mode 1
  always_comb begin
    k = mode_i ? (key_i & KeyMask) : {32'd0, key_i[31:0]};
    h = k[31:0] ^ k[63:32];
    hk_o.key = k;
    hk_o.tag = (h < 32'd2) ? (h + 32'd2) : h;
  end
endmodule
`default_nettype wire
